// ===== src/modexp_pkg.sv =====
package modexp_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int BASE_W = 32;
  localparam int EXP_W = 31;
  localparam int MOD_W = 31;
  localparam int PROD_W = 2 * MOD_W;
  localparam int IN_TDATA_W = 96;
  localparam int OUT_TDATA_W = 32;
  localparam int STEP_CNT_W = $clog2(PROD_W);
  localparam int BIT_IDX_W = $clog2(EXP_W);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_START = 6'b000100,
    S_WAIT  = 6'b001000,
    S_OUT   = 6'b010000,
    S_ZERO  = 6'b100000
  } state_t;

  // What the remainder unit is currently reducing.
  typedef enum logic [2:0] {
    K_BASE   = 3'b001,
    K_SQUARE = 3'b010,
    K_MULB   = 3'b100
  } kind_t;

endpackage

// ===== src/modexp_rem.sv =====
module modexp_rem
  import modexp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [MOD_W-1:0]  divisor,
  output logic              done,
  output logic [MOD_W-1:0]  remainder
);

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(PROD_W - 1);

  logic [PROD_W-1:0]     dvd;
  logic [MOD_W-1:0]      rem;
  logic [STEP_CNT_W-1:0] cnt;
  logic                  busy;
  logic [MOD_W:0]        trial;
  logic [MOD_W:0]        diff;
  logic [MOD_W-1:0]      rem_next;

  // Restoring remainder, one dividend bit per cycle. The partial remainder
  // stays below the divisor, so the shifted value stays below twice it.
  always_comb begin
    trial = {rem, dvd[PROD_W-1]};
    diff = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_next = diff[MOD_W-1:0];
    end else begin
      rem_next = trial[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[PROD_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ===== src/modular_exponentiation.sv =====
// Modular exponentiation by square-and-multiply.
// Input channel s_axis: one beat carries base (signed), exponent and modulus.
// Output channel m_axis: one beat per input with base^exponent mod modulus,
// always in 0 to modulus-1. A zero modulus returns 0.
// Only the low DATA_WIDTH bits of base count, sign-extended from the top one.
// The block works on one item at a time: s_axis_tready is high only while
// idle, and drops for the whole computation and until the result is taken.
// Every modular reduction runs through one shared remainder unit that
// retires one dividend bit per cycle, stepping S_MUL (multiply), then
// S_START (handoff to the unit), then S_WAIT. An item needs one
// reduction for the base and 31 squarings, plus one extra reduction
// per set exponent bit. The base reduction has no multiply step and
// starts at S_START. A zero modulus skips the remainder unit and goes
// through S_ZERO to S_OUT, where the result beat is presented.
// The result beat is held in an output register until m_axis_tready is seen;
// a stalled receiver simply keeps the block from taking the next item.
// Synchronous reset clears the sequencer to idle; no result is pending.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] base, [62:32] exponent, [93:63] modulus, [95:94] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [30:0] power_residue, [31] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [MOD_W-1:0] ONE = MOD_W'(1);

  state_t               state;
  kind_t                kind;
  logic [EXP_W-1:0]     exp_r;
  logic [MOD_W-1:0]     mod_r;
  logic [MOD_W-1:0]     base_r;
  logic [MOD_W-1:0]     acc;
  logic [PROD_W-1:0]    prod;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic                 neg;
  logic                 rem_done;
  logic [MOD_W-1:0]     rem_val;

  logic [BASE_W-1:0]     in_base;
  logic [EXP_W-1:0]      in_exp;
  logic [MOD_W-1:0]      in_mod;
  logic [DATA_WIDTH-1:0] base_low;
  logic [DATA_WIDTH-1:0] base_mag;
  logic [MOD_W-1:0]      mul_b;
  logic [MOD_W-1:0]      base_res;
  logic                  in_fire;

  assign in_base = s_axis_tdata[BASE_W-1:0];
  assign in_exp = s_axis_tdata[BASE_W +: EXP_W];
  assign in_mod = s_axis_tdata[BASE_W + EXP_W +: MOD_W];
  assign base_low = in_base[DATA_WIDTH-1:0];
  // Magnitude of a negative base; the most negative value maps onto itself.
  assign base_mag = base_low[DATA_WIDTH-1] ? (~base_low + 1'b1) : base_low;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign mul_b = (kind == K_SQUARE) ? acc : base_r;
  assign base_res = (neg && (rem_val != '0)) ? (mod_r - rem_val) : rem_val;

  modexp_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (prod),
    .divisor  (mod_r),
    .done     (rem_done),
    .remainder(rem_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= (in_mod == '0) ? S_ZERO : S_START;
          end
        end
        S_MUL: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (rem_done) begin
            if ((kind == K_SQUARE) && exp_r[bit_idx]) begin
              state <= S_MUL;
            end else if ((kind != K_BASE) && (bit_idx == '0)) begin
              state <= S_OUT;
              m_axis_tvalid <= 1'b1;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_ZERO: begin
          state <= S_OUT;
          m_axis_tvalid <= 1'b1;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
            m_axis_tvalid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          m_axis_tvalid <= 1'b0;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          exp_r <= in_exp;
          mod_r <= in_mod;
          neg <= base_low[DATA_WIDTH-1];
          prod <= {{(PROD_W - DATA_WIDTH){1'b0}}, base_mag};
          kind <= K_BASE;
          acc <= '0;
        end
      end
      S_MUL: begin
        prod <= acc * mul_b;
      end
      S_WAIT: begin
        if (rem_done) begin
          case (kind)
            K_BASE: begin
              base_r <= base_res;
              acc <= (mod_r == ONE) ? '0 : ONE;
              bit_idx <= BIT_IDX_W'(EXP_W - 1);
              kind <= K_SQUARE;
            end
            K_SQUARE: begin
              acc <= rem_val;
              if (exp_r[bit_idx]) begin
                kind <= K_MULB;
              end else if (bit_idx != '0) begin
                bit_idx <= bit_idx - 1'b1;
              end
            end
            default: begin
              acc <= rem_val;
              kind <= K_SQUARE;
              if (bit_idx != '0) begin
                bit_idx <= bit_idx - 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - MOD_W){1'b0}}, acc};

endmodule

// ===== src/modexp_checker.sv =====
module modexp_checker
  import modexp_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat pending right after reset");

  // One item at a time: no new input while a result is waiting.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after a beat was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

  a_out_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[OUT_TDATA_W-1])
    else $error("result padding bit set");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);
